[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL modules.
// All checks sample on aclk and are off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SDP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SDP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sdp_pkg.sv]
package sdp_pkg;

    localparam int TICKS_PER_SECOND = 1000000;
    localparam int MIN_SPEED        = 100;
    localparam int MAX_SPEED        = 5000;
    localparam int COUNT_BITS       = 16;
    localparam int SPEED_BITS       = 16;
    localparam int PERIOD_BITS      = 14;
    localparam int PERIOD_MAX       = (1 << PERIOD_BITS) - 1;
    localparam int LOW_RESET        = 100;
    localparam int HIGH_TICKS       = 2;
    localparam int SETTLE_TICKS     = 5;

    // Restoring divider geometry: dividend bits, divisor bits, bit counter.
    localparam int TICKS_BITS   = $clog2(TICKS_PER_SECOND + 1);
    localparam int DIVR_BITS    = $clog2(MAX_SPEED + 1);
    localparam int DIV_CNT_BITS = $clog2(TICKS_BITS);
    localparam logic [TICKS_BITS-1:0] TICKS_VEC = TICKS_BITS'(TICKS_PER_SECOND);

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_HIGH,
        PH_LOW
    } phase_t;

    typedef struct packed {
        logic load_run;
        logic load_high;
        logic load_low;
        logic dec_timer;
        logic dec_steps;
    } sdp_cmd_t;

    typedef struct packed {
        logic timer_last;
        logic steps_last;
    } sdp_stat_t;

    typedef struct packed {
        logic step_level;
        logic busy_res;
        logic rejected;
        logic run_done;
    } sdp_res_t;

endpackage

[hw/rtl/step_dir_pulse_generator.sv]
// Step/direction pulse generator for a stepper motor.
// Slave stream: s_tuser selects the transaction kind (0 = one microsecond
// tick, 1 = run command); s_tdata carries the signed step count for a run.
// Master stream: one result per accepted transaction with the step and
// direction pin levels, busy and rejected flags; m_tlast marks the tick that
// ends the last low time of a run.
// A run with a nonzero count taken while idle sets direction and waits 5
// ticks, then emits |count| pulses of 2 ticks high and the programmed low
// time. A run while busy is flagged rejected. The speed register (cfg_wr_en/
// cfg_wr_data) is clamped to 100..5000 steps/s and the low time is
// 1000000/speed ticks. Throughput: one transaction per cycle while s_tready
// is high. The result is registered and valid in the cycle after acceptance.
// A speed write runs a one-bit-per-cycle restoring divider, then loads the
// low time; s_tready is low meanwhile. When the receiver stalls, the result
// holds and s_tready drops until it is taken. Reset returns to idle,
// direction 0, low time 100 ticks, and clears any pending result and division.
module step_dir_pulse_generator
    import sdp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [SPEED_BITS-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] step_count
    input  logic                  s_tuser,   // [0] func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] step_level, [1] dir_level,
                                             // [2] busy_res, [3] rejected, [7:4] zero
    output logic                  m_tlast    // run_done
);

    sdp_cmd_t  cmd;
    sdp_stat_t stat;
    sdp_res_t  res;
    logic      item_fire;
    logic      dir_next;
    logic      div_busy;
    logic      m_valid_reg, m_valid_next;
    logic [3:0] m_data_reg;
    logic      m_last_reg;

    assign s_tready  = !div_busy && (!m_valid_reg || m_tready);
    assign item_fire = s_tvalid && s_tready;

    sdp_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_fire     (item_fire),
        .func          (s_tuser),
        .count_nonzero (s_tdata != '0),
        .stat          (stat),
        .cmd           (cmd),
        .res           (res)
    );

    sdp_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_count  (signed'(s_tdata[COUNT_BITS-1:0])),
        .cmd         (cmd),
        .stat        (stat),
        .dir_next    (dir_next),
        .div_busy    (div_busy)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (item_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (item_fire) begin
            m_data_reg <= {res.rejected, res.busy_res, dir_next, res.step_level};
            m_last_reg <= res.run_done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_data_reg};
    assign m_tlast  = m_last_reg;

endmodule

[hw/rtl/sdp_div.sv]
`include "assert_macros.svh"

module sdp_div
    import sdp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [SPEED_BITS-1:0] speed,
    output logic                  busy,
    output logic                  done,
    output logic [TICKS_BITS-1:0] quotient
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIVR_BITS-1:0]    div_reg, div_next;
    logic [DIVR_BITS-1:0]    rem_reg, rem_next;
    logic [TICKS_BITS-1:0]   quo_reg, quo_next;
    logic [DIVR_BITS-1:0]    clamped;
    logic [DIVR_BITS:0]      shifted;
    logic [DIVR_BITS:0]      diff;
    logic                    ge;

    always_comb begin
        if (speed < SPEED_BITS'(MIN_SPEED)) begin
            clamped = DIVR_BITS'(MIN_SPEED);
        end else if (speed > SPEED_BITS'(MAX_SPEED)) begin
            clamped = DIVR_BITS'(MAX_SPEED);
        end else begin
            clamped = speed[DIVR_BITS-1:0];
        end
    end

    // One quotient bit per cycle, dividend bits taken from the top down.
    assign shifted = {rem_reg, TICKS_VEC[cnt_reg]};
    assign diff    = shifted - {1'b0, div_reg};
    assign ge      = (shifted >= {1'b0, div_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(TICKS_BITS - 1);
            div_next  = clamped;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DIVR_BITS-1:0] : shifted[DIVR_BITS-1:0];
            quo_next = {quo_reg[TICKS_BITS-2:0], ge};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // Stay busy through the load cycle so no item sees the old low time.
    assign busy     = busy_reg || done_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    `SDP_ASSERT_NXT(a_div_done_idle, done_reg, !busy_reg || $past(start), "divider busy after done")

endmodule

[hw/rtl/sdp_datapath.sv]
`include "assert_macros.svh"

module sdp_datapath
    import sdp_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [SPEED_BITS-1:0]        cfg_wr_data,
    input  logic signed [COUNT_BITS-1:0] step_count,
    input  sdp_cmd_t                     cmd,
    output sdp_stat_t                    stat,
    output logic                         dir_next,
    output logic                         div_busy
);

    logic [PERIOD_BITS-1:0] low_period_reg, low_period_next;
    logic [PERIOD_BITS-1:0] timer_reg, timer_next;
    logic [COUNT_BITS-1:0]  steps_reg, steps_next;
    logic                   dir_reg;
    logic                   div_done;
    logic [TICKS_BITS-1:0]  quotient;
    logic [COUNT_BITS-1:0]  magnitude;

    sdp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cfg_wr_en),
        .speed    (cfg_wr_data),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // Saturate the quotient to the timer width and never store zero.
    always_comb begin
        low_period_next = low_period_reg;
        if (div_done) begin
            if (quotient > TICKS_BITS'(PERIOD_MAX)) begin
                low_period_next = PERIOD_BITS'(PERIOD_MAX);
            end else if (quotient == '0) begin
                low_period_next = PERIOD_BITS'(1);
            end else begin
                low_period_next = quotient[PERIOD_BITS-1:0];
            end
        end
    end

    // Most negative count wraps to its own bit pattern, which is the right magnitude.
    assign magnitude = step_count[COUNT_BITS-1] ? (~step_count + 1'b1) : step_count;

    always_comb begin
        priority if (cmd.load_run) begin
            timer_next = PERIOD_BITS'(SETTLE_TICKS);
        end else if (cmd.load_high) begin
            timer_next = PERIOD_BITS'(HIGH_TICKS);
        end else if (cmd.load_low) begin
            timer_next = low_period_reg;
        end else if (cmd.dec_timer && timer_reg != '0) begin
            timer_next = timer_reg - 1'b1;
        end else begin
            timer_next = timer_reg;
        end
    end

    always_comb begin
        priority if (cmd.load_run) begin
            steps_next = magnitude;
        end else if (cmd.dec_steps && steps_reg != '0) begin
            steps_next = steps_reg - 1'b1;
        end else begin
            steps_next = steps_reg;
        end
    end

    assign dir_next = cmd.load_run ? !step_count[COUNT_BITS-1] : dir_reg;

    assign stat.timer_last = (timer_reg <= PERIOD_BITS'(1));
    assign stat.steps_last = (steps_reg <= COUNT_BITS'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_period_reg <= PERIOD_BITS'(LOW_RESET);
            timer_reg      <= '0;
            steps_reg      <= '0;
            dir_reg        <= 1'b0;
        end else begin
            low_period_reg <= low_period_next;
            timer_reg      <= timer_next;
            steps_reg      <= steps_next;
            dir_reg        <= dir_next;
        end
    end

    `SDP_ASSERT_NXT(a_period_nonzero, div_done, low_period_reg != '0, "low period loaded as zero")

endmodule

[hw/rtl/sdp_ctrl.sv]
`include "assert_macros.svh"

module sdp_ctrl
    import sdp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      item_fire,
    input  logic      func,
    input  logic      count_nonzero,
    input  sdp_stat_t stat,
    output sdp_cmd_t  cmd,
    output sdp_res_t  res
);

    phase_t state_reg, state_next;
    logic   is_run;
    logic   is_tick;
    logic   expire;

    assign is_run  = item_fire && (func == FUNC_RUN);
    assign is_tick = item_fire && (func == FUNC_TICK);
    assign expire  = is_tick && stat.timer_last;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            PH_IDLE: begin
                if (is_run && count_nonzero) state_next = PH_SETTLE;
            end
            PH_SETTLE: begin
                if (expire) state_next = PH_HIGH;
            end
            PH_HIGH: begin
                if (expire) state_next = PH_LOW;
            end
            PH_LOW: begin
                if (expire) state_next = stat.steps_last ? PH_IDLE : PH_HIGH;
            end
            default: state_next = PH_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        res.rejected = is_run && (state_reg != PH_IDLE);
        res.run_done = 1'b0;
        unique case (state_reg)
            PH_IDLE: begin
                cmd.load_run = is_run && count_nonzero;
            end
            PH_SETTLE: begin
                cmd.dec_timer = is_tick;
                cmd.load_high = expire;
            end
            PH_HIGH: begin
                cmd.dec_timer = is_tick;
                cmd.load_low  = expire;
            end
            PH_LOW: begin
                cmd.dec_timer = is_tick;
                cmd.dec_steps = expire;
                cmd.load_high = expire && !stat.steps_last;
                res.run_done  = expire && stat.steps_last;
            end
            default: cmd = '0;
        endcase
        res.step_level = (state_next == PH_HIGH);
        res.busy_res   = (state_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PH_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SDP_ASSERT_NXT(a_done_idle, res.run_done, state_reg == PH_IDLE, "run done but not idle")
    `SDP_ASSERT_IMP(a_start_by_run,
        (state_reg == PH_SETTLE) && ($past(state_reg) == PH_IDLE),
        $past(is_run && count_nonzero), "run started without a run command")

endmodule

[test/step_dir_pulse_generator_checker.sv]
module step_dir_pulse_generator_checker
    import sdp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [SPEED_BITS-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,
    input  logic                  m_tlast,
    output int                    pending,
    output int                    mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    // m_tlast on top of m_tdata, lowest bit last in the list
    typedef struct packed {
        logic       run_done;
        logic [3:0] pad;
        logic       rejected;
        logic       busy_res;
        logic       dir_level;
        logic       step_level;
    } pin_word_t;

    logic [PERIOD_BITS-1:0] low_ticks;
    phase_t                 motor_phase;
    logic [PERIOD_BITS-1:0] phase_left;
    logic [COUNT_BITS-1:0]  pulses_left;
    logic                   dir_fwd;
    pin_word_t              pin_q[$];
    int                     fail_cnt = 0;

    function automatic logic [PERIOD_BITS-1:0] speed_to_period(input logic [SPEED_BITS-1:0] v);
        int sp;
        int q;
        sp = int'(v);
        if (sp < MIN_SPEED) begin
            sp = MIN_SPEED;
        end else if (sp > MAX_SPEED) begin
            sp = MAX_SPEED;
        end
        q = TICKS_PER_SECOND / sp;
        if (q > PERIOD_MAX) begin
            q = PERIOD_MAX;
        end
        if (q == 0) begin
            q = 1;
        end
        return PERIOD_BITS'(q);
    endfunction

    // Apply one transaction to the motor state and return the pin word it leaves.
    function automatic pin_word_t advance_motor(input logic func, input logic [15:0] cnt);
        pin_word_t w;
        logic      rej;
        logic      done;
        rej  = 1'b0;
        done = 1'b0;
        if (func == FUNC_RUN) begin
            if (motor_phase != PH_IDLE) begin
                rej = 1'b1;
            end else if (cnt != '0) begin
                dir_fwd     = ~cnt[15];
                // the most negative count wraps back to itself: 32768 steps
                pulses_left = cnt[15] ? (~cnt + 16'd1) : cnt;
                motor_phase = PH_SETTLE;
                phase_left  = PERIOD_BITS'(SETTLE_TICKS);
            end
        end else begin
            case (motor_phase)
                PH_SETTLE: begin
                    if (phase_left > 0) phase_left--;
                    if (phase_left == 0) begin
                        motor_phase = PH_HIGH;
                        phase_left  = PERIOD_BITS'(HIGH_TICKS);
                    end
                end
                PH_HIGH: begin
                    if (phase_left > 0) phase_left--;
                    if (phase_left == 0) begin
                        motor_phase = PH_LOW;
                        phase_left  = low_ticks;
                    end
                end
                PH_LOW: begin
                    if (phase_left > 0) phase_left--;
                    if (phase_left == 0) begin
                        if (pulses_left > 0) pulses_left--;
                        if (pulses_left == 0) begin
                            motor_phase = PH_IDLE;
                            done        = 1'b1;
                        end else begin
                            motor_phase = PH_HIGH;
                            phase_left  = PERIOD_BITS'(HIGH_TICKS);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        w            = '0;
        w.step_level = (motor_phase == PH_HIGH);
        w.dir_level  = dir_fwd;
        w.busy_res   = (motor_phase != PH_IDLE);
        w.rejected   = rej;
        w.run_done   = done;
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [3:0] exp_v,
                                        input logic [3:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        pin_word_t want;
        pin_word_t got;
        if (!aresetn) begin
            low_ticks   = PERIOD_BITS'(LOW_RESET);
            motor_phase = PH_IDLE;
            phase_left  = '0;
            pulses_left = '0;
            dir_fwd     = 1'b0;
            pin_q.delete();
        end else begin
            if (cfg_wr_en) begin
                low_ticks = speed_to_period(cfg_wr_data);
            end
            if (m_tvalid && m_tready) begin
                got = pin_word_t'({m_tlast, m_tdata});
                if (pin_q.size() == 0) begin
                    $error("result transaction with nothing expected: tdata=%h tlast=%b",
                           m_tdata, m_tlast);
                    fail_cnt++;
                end else begin
                    want = pin_q.pop_front();
                    check_field("step_level", 4'(want.step_level), 4'(got.step_level));
                    check_field("dir_level", 4'(want.dir_level), 4'(got.dir_level));
                    check_field("busy_res", 4'(want.busy_res), 4'(got.busy_res));
                    check_field("rejected", 4'(want.rejected), 4'(got.rejected));
                    check_field("run_done", 4'(want.run_done), 4'(got.run_done));
                    check_field("tdata pad", want.pad, got.pad);
                end
            end
            if (s_tvalid && s_tready) begin
                pin_q.push_back(advance_motor(s_tuser, s_tdata));
            end
        end
        pending    <= pin_q.size();
        mismatches <= fail_cnt;
    end

endmodule

[test/step_dir_pulse_generator_tb.sv]
module step_dir_pulse_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sdp_pkg::*;

    // total input transactions before the final long run
    localparam int ITEM_TARGET     = 925;
    // most transactions one random pass can take: a few ticks, a one-step run
    // at the slowest random speed and the commands turned away during it
    localparam int ITER_BUDGET     = 300;
    // shortest run with commands mixed in is settle + high + the low time at
    // MAX_SPEED, so commands inside this many ticks of a run are always turned away
    localparam int NOISE_WINDOW    = 100;
    localparam int LONG_HOLD       = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int END_WAIT        = 16;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [SPEED_BITS-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata     = '0;    // [15:0] step_count
    logic                  s_tuser     = 1'b0;  // [0] func
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [7:0]            m_tdata;             // [0] step, [1] dir, [2] busy, [3] rejected
    logic                  m_tlast;             // run_done

    int pending;
    int mismatches;
    int txn_in        = 0;
    int txn_out       = 0;
    int runs_done     = 0;
    int runs_rejected = 0;
    int speed_writes  = 0;
    int quiet_cycles  = 0;
    bit steady        = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    step_dir_pulse_generator u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    step_dir_pulse_generator_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .pending     (pending),
        .mismatches  (mismatches)
    );

    // Traffic counters and the watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) txn_in++;
            if (m_tvalid && m_tready) begin
                txn_out++;
                if (m_tlast) runs_done++;
                if (m_tdata[3]) runs_rejected++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, pending);
                $display("step_dir_pulse_generator_tb: errors");
                $finish;
            end
        end
    end

    // Result side: random stalls, long open stretches, and one long hold.
    initial begin : receiver
        int on_len;
        int off_len;
        int r;
        bit long_hold_done;
        long_hold_done = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            on_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 8);
            r       = $urandom_range(0, 99);
            off_len = (r < 50) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            if (!long_hold_done && txn_out > 300) begin
                long_hold_done = 1'b1;
                off_len        = LONG_HOLD;
            end
            m_tready <= 1'b1;
            repeat (on_len) @(posedge aclk);
            if (off_len > 0) begin
                m_tready <= 1'b0;
                repeat (off_len) @(posedge aclk);
            end
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Keep random low times at 250 ticks or less so runs stay short.
    function automatic logic [SPEED_BITS-1:0] random_speed();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return SPEED_BITS'($urandom_range(4000, MAX_SPEED));
        return SPEED_BITS'($urandom_range(MAX_SPEED + 1, 65535));
    endfunction

    function automatic logic [15:0] random_count();
        return $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
    endfunction

    // Present one transaction and hold it until it is taken.
    task automatic send_item(input logic func, input logic [15:0] cnt);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= cnt;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop offering and wait until every result is back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_speed(input logic [SPEED_BITS-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        // the divider holds off the input channel until the new low time is loaded
        do @(posedge aclk); while (!s_tready);
        speed_writes++;
    endtask

    // Tick until the run started before start_done was taken reports done.
    task automatic finish_run(input int start_done, input bit with_noise);
        int ticks;
        ticks = 0;
        while (runs_done == start_done) begin
            if (with_noise && ticks < NOISE_WINDOW && $urandom_range(0, 11) == 0) begin
                send_item(FUNC_RUN, 16'($urandom));
            end else begin
                send_item(FUNC_TICK, 16'($urandom));
                ticks++;
            end
        end
    endtask

    task automatic motor_run(input logic [15:0] cnt, input bit with_noise);
        int start_done;
        start_done = runs_done;
        send_item(FUNC_RUN, cnt);
        finish_run(start_done, with_noise);
    endtask

    initial begin : stimulus
        int done_mark;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // idle ticks and a zero-count run change nothing
        send_item(FUNC_TICK, 16'hFFFF);
        send_item(FUNC_RUN, 16'h0000);
        send_item(FUNC_TICK, 16'h8000);

        // two steps at the reset low time, with commands turned away while busy
        done_mark = runs_done;
        send_item(FUNC_RUN, 16'h0002);
        send_item(FUNC_RUN, 16'h0000);
        send_item(FUNC_RUN, 16'h8000);
        send_item(FUNC_RUN, 16'h7FFF);
        finish_run(done_mark, 1'b0);

        // clamp at both ends, then run at the top speed
        drain_results();
        write_speed(16'd0);
        write_speed(16'hFFFF);
        motor_run(16'hFFFF, 1'b1);

        drain_results();
        write_speed(16'd99);
        write_speed(16'd5001);
        write_speed(16'd4000);

        while (txn_in + ITER_BUDGET < ITEM_TARGET) begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1)) begin
                drain_results();
                write_speed(random_speed());
            end
            repeat ($urandom_range(0, 4)) send_item(FUNC_TICK, 16'($urandom));
            if ($urandom_range(0, 9) == 0) begin
                send_item(FUNC_RUN, 16'h0000);
            end else begin
                motor_run(random_count(), 1'b1);
            end
        end
        steady = 1'b0;

        // top up with idle ticks
        while (txn_in < ITEM_TARGET) send_item(FUNC_TICK, 16'($urandom));

        // the most negative count gives the longest run; leave it going at the end
        drain_results();
        write_speed(random_speed());
        send_item(FUNC_RUN, 16'h8000);
        repeat (20) send_item(FUNC_TICK, 16'($urandom));

        drain_results();
        repeat (END_WAIT) @(posedge aclk);
        $display("coverage: %0d transactions in, %0d results compared, %0d speed writes",
                 txn_in, txn_out, speed_writes);
        $display("coverage: %0d runs completed, %0d run commands turned away while busy",
                 runs_done, runs_rejected);
        if (mismatches == 0 && pending == 0) begin
            $display("step_dir_pulse_generator_tb: clean");
        end else begin
            $display("step_dir_pulse_generator_tb: errors");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/sdp_pkg.sv
hw/rtl/sdp_div.sv
hw/rtl/sdp_datapath.sv
hw/rtl/sdp_ctrl.sv
hw/rtl/step_dir_pulse_generator.sv
test/step_dir_pulse_generator_checker.sv
test/step_dir_pulse_generator_tb.sv
